FILE: rtl/itp_pkg.sv
`default_nettype none

package itp_pkg;

  // Stream widths
  localparam int unsigned TDATA_W = 40;
  localparam int unsigned TUSER_W = 3;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAT_W  = 2;

  // Input token kinds
  typedef enum logic [2:0] {
    CMD_OPERAND = 3'd0,
    CMD_OPERATOR = 3'd1,
    CMD_OPEN = 3'd2,
    CMD_CLOSE = 3'd3,
    CMD_COMMA = 3'd4,
    CMD_END = 3'd5
  } cmd_t;

  // Operator codes of note
  localparam logic [CODE_W-1:0] OP_ADD     = 4'd0;
  localparam logic [CODE_W-1:0] OP_SUB     = 4'd1;
  localparam logic [CODE_W-1:0] OP_MUL     = 4'd2;
  localparam logic [CODE_W-1:0] OP_DIV     = 4'd3;
  localparam logic [CODE_W-1:0] OP_POW     = 4'd4;
  localparam logic [CODE_W-1:0] OP_SIN     = 4'd5;
  localparam logic [CODE_W-1:0] OP_COS     = 4'd6;
  localparam logic [CODE_W-1:0] OP_TAN     = 4'd7;
  localparam logic [CODE_W-1:0] OP_SQRT    = 4'd8;
  localparam logic [CODE_W-1:0] OP_LAST    = OP_SQRT;
  localparam logic [CODE_W-1:0] OPEN_MARK  = 4'hF;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNBAL    = 2'd2;

  // Kind of result item
  typedef enum logic [1:0] {
    K_OPERAND,
    K_OPERATOR,
    K_STATUS
  } kind_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_OPND,
    S_OPER,
    S_OPEN,
    S_CLOSE,
    S_SQRT,
    S_ENDCHK
  } state_t;

  // Stack commands and status
  typedef struct packed {
    logic load;
    logic push_op;
    logic push_open;
    logic pop;
    logic rearm;
  } stk_cmd_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic              top_open;
    logic              top_sqrt;
    logic              pop_ok;
    logic [CODE_W-1:0] top_code;
  } stk_stat_t;

  // Output stage commands and status
  typedef struct packed {
    logic              load;
    logic              emit;
    kind_t             kind;
    logic [STAT_W-1:0] status;
    logic              flush;
  } em_cmd_t;

  typedef struct packed {
    logic hold_valid;
    logic out_free;
    logic can_emit;
  } em_stat_t;

  // Precedence; brackets and unused codes rank lowest
  function automatic logic [2:0] prec_of(input logic [CODE_W-1:0] code);
    logic [2:0] p;
    case (code)
      OP_ADD, OP_SUB: p = 3'd1;
      OP_MUL, OP_DIV: p = 3'd2;
      OP_POW:         p = 3'd3;
      OP_SIN, OP_COS, OP_TAN, OP_SQRT: p = 3'd4;
      default:        p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/itp_stack.sv
`default_nettype none

module itp_stack #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire itp_pkg::stk_cmd_t         cmd,
  input  wire logic [itp_pkg::CODE_W-1:0] in_code,
  output itp_pkg::stk_stat_t             stat
);
  import itp_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [CODE_W-1:0] mem [STACK_DEPTH];
  logic [CW-1:0]     count_r, count_nxt;
  logic [CODE_W-1:0] top_r;
  logic [CODE_W-1:0] code_r;
  logic [CW-1:0]     top_idx;

  logic              rearm_eff;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CODE_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;

  // Next depth; reset behaves as a re-arm
  assign rearm_eff = cmd.rearm | ~rst_n;

  always_comb begin
    if (rearm_eff) begin
      count_nxt = CW'(1);
    end else if (cmd.push_op || cmd.push_open) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // Write port: push at depth, re-arm puts the sentinel at the bottom
  assign wr_en   = cmd.push_op | cmd.push_open | rearm_eff;
  assign wr_addr = rearm_eff ? '0 : count_r[AW-1:0];
  assign wr_data = (cmd.push_op && !rearm_eff) ? code_r : OPEN_MARK;

  // Read port follows the next top of stack
  assign top_idx = count_nxt - CW'(1);
  assign rd_addr = (count_nxt == '0) ? '0 : top_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      top_r <= wr_data;
    end else begin
      top_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(1);
    end else begin
      count_r <= count_nxt;
    end
  end

  // Operator code of the item in hand
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r <= in_code;
    end
  end

  // Status towards the controller
  always_comb begin
    stat.empty    = (count_r == '0);
    stat.full     = (count_r == CW'(STACK_DEPTH));
    stat.top_open = (top_r == OPEN_MARK);
    stat.top_sqrt = (top_r == OP_SQRT);
    stat.pop_ok   = (count_r != '0) && (prec_of(code_r) <= prec_of(top_r));
    stat.top_code = top_r;
  end

endmodule

`default_nettype wire

FILE: rtl/itp_emit.sv
`default_nettype none

module itp_emit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire itp_pkg::em_cmd_t            cmd,
  input  wire logic [itp_pkg::CODE_W-1:0]  op_code,
  input  wire logic [itp_pkg::VALUE_W-1:0] in_value,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic                             out_is_operand,
  output logic [itp_pkg::CODE_W-1:0]       out_code,
  output logic [itp_pkg::VALUE_W-1:0]      out_value,
  output logic [itp_pkg::STAT_W-1:0]       out_status,
  output logic                             out_last,
  output itp_pkg::em_stat_t                stat
);
  import itp_pkg::*;

  logic [VALUE_W-1:0] value_r;

  // Held result: sent once it is known whether another follows
  logic               hold_valid_r;
  logic               hold_opnd_r;
  logic [CODE_W-1:0]  hold_code_r;
  logic [VALUE_W-1:0] hold_value_r;
  logic [STAT_W-1:0]  hold_status_r;

  logic               out_valid_r;
  logic               out_opnd_r;
  logic [CODE_W-1:0]  out_code_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [STAT_W-1:0]  out_status_r;
  logic               out_last_r;

  logic               out_free;
  logic               new_opnd;
  logic [CODE_W-1:0]  new_code;
  logic [VALUE_W-1:0] new_value;
  logic               move;

  assign out_free  = ~out_valid_r | out_ready;
  assign new_opnd  = (cmd.kind == K_OPERAND);
  assign new_code  = (cmd.kind == K_OPERATOR) ? op_code : '0;
  assign new_value = new_opnd ? value_r : '0;
  // Held result moves on when displaced or flushed
  assign move      = (cmd.emit && hold_valid_r) || cmd.flush;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value;
    end
  end

  // Hold stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      hold_valid_r <= 1'b1;
    end else if (cmd.flush) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hold_opnd_r   <= new_opnd;
      hold_code_r   <= new_code;
      hold_value_r  <= new_value;
      hold_status_r <= (cmd.kind == K_STATUS) ? cmd.status : ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_opnd_r   <= hold_opnd_r;
      out_code_r   <= hold_code_r;
      out_value_r  <= hold_value_r;
      out_status_r <= hold_status_r;
      out_last_r   <= cmd.flush;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_operand = out_opnd_r;
  assign out_code       = out_code_r;
  assign out_value      = out_value_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

  always_comb begin
    stat.hold_valid = hold_valid_r;
    stat.out_free   = out_free;
    stat.can_emit   = ~hold_valid_r | out_free;
  end

endmodule

`default_nettype wire

FILE: rtl/itp_ctrl.sv
`default_nettype none

module itp_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [2:0]                 in_command,
  input  wire logic [itp_pkg::CODE_W-1:0] in_code,
  output logic                            in_ready,
  input  wire itp_pkg::stk_stat_t         stk_stat,
  input  wire itp_pkg::em_stat_t          em_stat,
  output itp_pkg::stk_cmd_t               stk_cmd,
  output itp_pkg::em_cmd_t                em_cmd
);
  import itp_pkg::*;

  state_t state_r, state_nxt;
  logic   is_end_r, is_end_nxt;
  logic   go;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      is_end_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      is_end_r <= is_end_nxt;
    end
  end

  assign go = em_stat.can_emit;

  always_comb begin
    state_nxt  = state_r;
    is_end_nxt = is_end_r;
    in_ready   = 1'b0;
    accept     = 1'b0;
    stk_cmd    = '0;
    em_cmd     = '0;
    em_cmd.kind   = K_OPERATOR;
    em_cmd.status = ST_OK;

    case (state_r)
      S_IDLE: begin
        // Send the held result as last, and take the next item meanwhile
        in_ready     = ~em_stat.hold_valid | em_stat.out_free;
        em_cmd.flush = em_stat.hold_valid & em_stat.out_free;
        accept       = in_valid & in_ready;
        if (accept) begin
          stk_cmd.load = 1'b1;
          em_cmd.load  = 1'b1;
          case (cmd_t'(in_command))
            CMD_OPERAND: state_nxt = S_OPND;
            CMD_OPERATOR: begin
              if (in_code <= OP_LAST) begin
                state_nxt = S_OPER;
              end
            end
            CMD_OPEN: state_nxt = S_OPEN;
            CMD_CLOSE: begin
              state_nxt  = S_CLOSE;
              is_end_nxt = 1'b0;
            end
            CMD_END: begin
              state_nxt  = S_CLOSE;
              is_end_nxt = 1'b1;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_OPND: begin
        if (go) begin
          em_cmd.emit = 1'b1;
          em_cmd.kind = K_OPERAND;
          state_nxt   = S_IDLE;
        end
      end

      // Pop operators of equal or higher rank, then push; a full stack reports overflow
      S_OPER: begin
        if (stk_stat.pop_ok) begin
          if (go) begin
            stk_cmd.pop = 1'b1;
            em_cmd.emit = 1'b1;
          end
        end else if (stk_stat.full) begin
          if (go) begin
            em_cmd.emit   = 1'b1;
            em_cmd.kind   = K_STATUS;
            em_cmd.status = ST_OVERFLOW;
            state_nxt     = S_IDLE;
          end
        end else begin
          stk_cmd.push_op = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      S_OPEN: begin
        if (stk_stat.full) begin
          if (go) begin
            em_cmd.emit   = 1'b1;
            em_cmd.kind   = K_STATUS;
            em_cmd.status = ST_OVERFLOW;
            state_nxt     = S_IDLE;
          end
        end else begin
          stk_cmd.push_open = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      // Pop down to the open bracket; none found is unbalanced
      S_CLOSE: begin
        if (!stk_stat.empty && !stk_stat.top_open) begin
          if (go) begin
            stk_cmd.pop = 1'b1;
            em_cmd.emit = 1'b1;
          end
        end else if (stk_stat.empty) begin
          if (go) begin
            em_cmd.emit   = 1'b1;
            em_cmd.kind   = K_STATUS;
            em_cmd.status = ST_UNBAL;
            stk_cmd.rearm = is_end_r;
            state_nxt     = S_IDLE;
          end
        end else begin
          stk_cmd.pop = 1'b1;
          state_nxt   = S_SQRT;
        end
      end

      // A sqrt just beneath the bracket goes with it
      S_SQRT: begin
        if (!stk_stat.empty && stk_stat.top_sqrt) begin
          if (go) begin
            stk_cmd.pop = 1'b1;
            em_cmd.emit = 1'b1;
            state_nxt   = is_end_r ? S_ENDCHK : S_IDLE;
          end
        end else begin
          state_nxt = is_end_r ? S_ENDCHK : S_IDLE;
        end
      end

      // End token: leftover entries mean open brackets remain
      S_ENDCHK: begin
        if (!stk_stat.empty) begin
          if (go) begin
            em_cmd.emit   = 1'b1;
            em_cmd.kind   = K_STATUS;
            em_cmd.status = ST_UNBAL;
            stk_cmd.rearm = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          stk_cmd.rearm = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/infix_to_postfix_converter.sv
// Infix to postfix token converter.
// Input stream: one infix token per item. in_tuser carries the token kind
// (operand, operator, open, close, comma, end); in_tdata carries the operator
// code and the operand handle. Output stream: one postfix token or status
// report per item, with out_tlast on the final item that a token causes.
// A comma or an ignored token is dropped as it is taken. An operand is
// sent on, an open bracket pushed; an operator first pops every operator
// of equal or higher rank, one stack read per pop, then is pushed. A close
// bracket pops down to its bracket, then does the bracket drop and the
// sqrt check; end adds the end check. No new token is taken until a
// token's steps are done. Results wait one stage so that tlast can be set:
// a result reaches the output register when the next one of its token is
// made, the last one from the idle state after the token's final step once
// the output register is free. A full stack drops the push and reports
// overflow; a missing or leftover bracket reports unbalanced, and end
// re-arms the stack. Reset leaves the stack with the bottom open bracket
// alone and both streams empty. A stalled receiver holds the output
// register and the held result; the block then stops and takes no new
// token until room returns.
`default_nettype none

module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // [3:0] op_code, [35:4] operand_value, [39:36] zero
  input  wire logic [itp_pkg::TDATA_W-1:0] in_tdata,
  // [2:0] command
  input  wire logic [itp_pkg::TUSER_W-1:0] in_tuser,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [3:0] out_op_code, [35:4] out_value, [39:36] zero
  output logic [itp_pkg::TDATA_W-1:0]      out_tdata,
  // [0] is_operand, [2:1] status
  output logic [itp_pkg::TUSER_W-1:0]      out_tuser,
  output logic                             out_tlast
);
  import itp_pkg::*;

  stk_cmd_t  stk_cmd;
  stk_stat_t stk_stat;
  em_cmd_t   em_cmd;
  em_stat_t  em_stat;

  logic               o_opnd;
  logic [CODE_W-1:0]  o_code;
  logic [VALUE_W-1:0] o_value;
  logic [STAT_W-1:0]  o_status;

  itp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_command (in_tuser),
    .in_code    (in_tdata[CODE_W-1:0]),
    .in_ready   (in_tready),
    .stk_stat   (stk_stat),
    .em_stat    (em_stat),
    .stk_cmd    (stk_cmd),
    .em_cmd     (em_cmd)
  );

  itp_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (stk_cmd),
    .in_code (in_tdata[CODE_W-1:0]),
    .stat    (stk_stat)
  );

  itp_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (em_cmd),
    .op_code        (stk_stat.top_code),
    .in_value       (in_tdata[CODE_W+VALUE_W-1:CODE_W]),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_is_operand (o_opnd),
    .out_code       (o_code),
    .out_value      (o_value),
    .out_status     (o_status),
    .out_last       (out_tlast),
    .stat           (em_stat)
  );

  // Pack result fields
  assign out_tdata = {{(TDATA_W - CODE_W - VALUE_W){1'b0}}, o_value, o_code};
  assign out_tuser = {o_status, o_opnd};

`ifndef SYNTHESIS
  // No push onto a full stack
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    stk_stat.full |-> !(stk_cmd.push_op || stk_cmd.push_open))
    else $error("push onto full operator stack");

  // A new result never overruns a held one that cannot move on
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    em_cmd.emit |-> em_stat.can_emit)
    else $error("result emitted with no room");

  // Flushing only sends a real held result
  a_flush_held: assert property (@(posedge clk) disable iff (!rst_n)
    em_cmd.flush |-> (em_stat.hold_valid && em_stat.out_free))
    else $error("flush without held result");

  // After a flush the output carries a last item
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    em_cmd.flush |=> (out_tvalid && out_tlast))
    else $error("flushed result not marked last");
`endif

endmodule

`default_nettype wire
